// ===== rtl/hid2xt_pkg.sv =====
// ----------------------------------------------------------------------------
// hid2xt_pkg: shared types, constants and tables for the HID to XT translator
// Holds the item and burst types, the scan code tables and the key helpers.
// ----------------------------------------------------------------------------
package hid2xt_pkg;

	// Config and timer widths, longest byte burst and its count width.
	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 1;
	localparam int BURST_MAX = 6;
	localparam int CNT_W     = 3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [CFG_W-1:0] REPEAT_DELAY_RST  = 20'd500000;
	localparam logic [CFG_W-1:0] REPEAT_PERIOD_RST = 20'd91743;

	// Scan code bytes.
	localparam logic [7:0] XT_EXT_PREFIX   = 8'he0;
	localparam logic [7:0] XT_PAUSE_PREFIX = 8'he1;
	localparam logic [7:0] XT_BREAK_BIT    = 8'h80;
	localparam logic [7:0] XT_SELF_TEST_OK = 8'haa;
	localparam logic [7:0] XT_SCROLL_MAKE  = 8'h46;
	localparam logic [7:0] XT_SCROLL_BREAK = 8'hc6;
	localparam logic [7:0] XT_CTRL_MAKE    = 8'h1d;
	localparam logic [7:0] XT_CTRL_BREAK   = 8'h9d;
	localparam logic [7:0] XT_NUM_MAKE     = 8'h45;
	localparam logic [7:0] XT_NUM_BREAK    = 8'hc5;

	// HID usages with special handling.
	localparam logic [7:0] USAGE_LAST_PLAIN = 8'h73;
	localparam logic [7:0] USAGE_FIRST_MOD  = 8'he0;
	localparam logic [7:0] USAGE_LAST_MOD   = 8'he7;
	localparam logic [7:0] USAGE_NUM_LOCK   = 8'h53;
	localparam logic [7:0] USAGE_CAPS_LOCK  = 8'h39;
	localparam logic [7:0] USAGE_SCROLL     = 8'h47;
	localparam logic [7:0] USAGE_PAUSE      = 8'h48;
	localparam logic [7:0] CTRL_MASK        = 8'h11;

	// LED bit positions.
	localparam int LED_NUM    = 0;
	localparam int LED_CAPS   = 1;
	localparam int LED_SCROLL = 2;

	typedef enum logic [1:0] {
		ACT_KEY        = 2'd0,
		ACT_TICK       = 2'd1,
		ACT_HOST_RESET = 2'd2
	} action_t;

	// One input item as held in the input register.
	typedef struct packed {
		logic [1:0] action;
		logic [7:0] usage_code;
		logic       pressed;
		logic [7:0] modifier_bits;
	} item_t;

	// The bytes caused by one item, first byte in slot zero.
	typedef struct packed {
		logic [BURST_MAX-1:0][7:0] bytes;
		logic [CNT_W-1:0]          count;
		logic [2:0]                leds;
	} burst_t;

	// Make codes of usages 0x00 to 0x73, padded with zeros to 128 entries.
	localparam logic [7:0] USAGE_TABLE [0:127] = '{
		8'h00, 8'hff, 8'hfc, 8'h00, 8'h1e, 8'h30, 8'h2e, 8'h20,
		8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24, 8'h25, 8'h26,
		8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1f, 8'h14,
		8'h16, 8'h2f, 8'h11, 8'h2d, 8'h15, 8'h2c, 8'h02, 8'h03,
		8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a, 8'h0b,
		8'h1c, 8'h01, 8'h0e, 8'h0f, 8'h39, 8'h0c, 8'h0d, 8'h1a,
		8'h1b, 8'h2b, 8'h2b, 8'h27, 8'h28, 8'h29, 8'h33, 8'h34,
		8'h35, 8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e, 8'h3f, 8'h40,
		8'h41, 8'h42, 8'h43, 8'h44, 8'h57, 8'h58, 8'h37, 8'h46,
		8'h46, 8'h52, 8'h47, 8'h49, 8'h53, 8'h4f, 8'h51, 8'h4d,
		8'h4b, 8'h50, 8'h48, 8'h45, 8'h35, 8'h37, 8'h4a, 8'h4e,
		8'h1c, 8'h4f, 8'h50, 8'h51, 8'h4b, 8'h4c, 8'h4d, 8'h47,
		8'h48, 8'h49, 8'h52, 8'h53, 8'h56, 8'h5d, 8'h5e, 8'h59,
		8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6a, 8'h6b,
		8'h6c, 8'h6d, 8'h6e, 8'h76, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	// Make codes of the eight modifier usages.
	localparam logic [7:0] MOD_TABLE [0:7] = '{
		8'h1d, 8'h2a, 8'h38, 8'h5b, 8'h1d, 8'h36, 8'h38, 8'h5c
	};

	function automatic logic is_modifier(input logic [7:0] u);
		return (u >= USAGE_FIRST_MOD) && (u <= USAGE_LAST_MOD);
	endfunction

	function automatic logic is_mapped(input logic [7:0] u);
		return (u <= USAGE_LAST_PLAIN) || is_modifier(u);
	endfunction

	function automatic logic is_extended(input logic [7:0] u);
		return (u == 8'h46) || ((u >= 8'h49) && (u <= 8'h52)) || (u == 8'h54) ||
			(u == 8'h58) || (u == 8'h65) || (u == 8'h66) ||
			((u > 8'he2) && (u != 8'he5));
	endfunction

	function automatic logic [7:0] make_code(input logic [7:0] u);
		logic [7:0] code;
		if (is_modifier(u)) begin
			code = MOD_TABLE[u[2:0]];
		end else if (u <= USAGE_LAST_PLAIN) begin
			code = USAGE_TABLE[u[6:0]];
		end else begin
			code = 8'h00;
		end
		return code;
	endfunction

endpackage

// ===== rtl/hid2xt_in_if.sv =====
// ----------------------------------------------------------------------------
// hid2xt_in_if: key event channel
// Carries one HID key event, tick or host reset per item.
// ----------------------------------------------------------------------------
interface hid2xt_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] usage_code;
	logic       pressed;
	logic [7:0] modifier_bits;

	modport source (output valid, action, usage_code, pressed, modifier_bits, input ready);
	modport sink (input valid, action, usage_code, pressed, modifier_bits, output ready);
endinterface

// ===== rtl/hid2xt_out_if.sv =====
// ----------------------------------------------------------------------------
// hid2xt_out_if: scan byte channel
// Carries one XT set-1 byte per item, with the end marker and the LED bits.
// ----------------------------------------------------------------------------
interface hid2xt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] scan_byte;
	logic       last_byte;
	logic [2:0] lock_leds;

	modport source (output valid, scan_byte, last_byte, lock_leds, input ready);
	modport sink (input valid, scan_byte, last_byte, lock_leds, output ready);
endinterface

// ===== rtl/usb_hid_to_xt_scancode_translator.sv =====
// ----------------------------------------------------------------------------
// usb_hid_to_xt_scancode_translator: HID key events to XT set-1 scan codes
// Registers each item, builds its byte sequence in one pass and sends the
// bytes one per cycle, while the receiver is ready, on the output channel.
// ----------------------------------------------------------------------------
// Flow: an accepted item waits in the input register until the byte register is free.
// Throughput: one item per cycle while items cause at most one byte and the receiver
// takes it; N bytes of one item (up to six) hold the single byte register until taken.
// Reset: LEDs, repeat key and repeat timer clear; the repeat delay resets to
// 500000 ticks and the repeat period to 91743 ticks; no bytes are pending.
module usb_hid_to_xt_scancode_translator (
	input  logic                               clk,
	input  logic                               arst_n,
	hid2xt_in_if.sink                          events,
	hid2xt_out_if.source                       codes,
	input  logic                               cfg_we,
	input  logic [hid2xt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hid2xt_pkg::CFG_W-1:0]       cfg_data
);

	logic [hid2xt_pkg::CFG_W-1:0]                 repeat_delay_q;
	logic [hid2xt_pkg::CFG_W-1:0]                 repeat_period_q;
	logic                                         valid_s1;
	hid2xt_pkg::item_t                            item_s1;
	hid2xt_pkg::burst_t                           enc_burst;
	logic [hid2xt_pkg::BURST_MAX-1:0][7:0]        bytes_q;
	logic [hid2xt_pkg::CNT_W-1:0]                 remaining_q;
	logic [2:0]                                   leds_q;
	logic                                         take;
	logic                                         burst_free;
	logic                                         advance;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_delay_q  <= hid2xt_pkg::REPEAT_DELAY_RST;
			repeat_period_q <= hid2xt_pkg::REPEAT_PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				hid2xt_pkg::CFG_REPEAT_DELAY:  repeat_delay_q  <= cfg_data;
				hid2xt_pkg::CFG_REPEAT_PERIOD: repeat_period_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Handshake: the input register moves on once the byte register is free.
	assign take       = codes.valid && codes.ready;
	assign burst_free = (remaining_q == '0) ||
		(remaining_q == hid2xt_pkg::CNT_W'(1) && take);
	assign advance    = valid_s1 && burst_free;
	assign events.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (events.ready) begin
			valid_s1 <= events.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (events.valid && events.ready) begin
			item_s1.action        <= events.action;
			item_s1.usage_code    <= events.usage_code;
			item_s1.pressed       <= events.pressed;
			item_s1.modifier_bits <= events.modifier_bits;
		end
	end

	hid2xt_encode u_encode (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item_s1),
		.commit        (advance),
		.repeat_delay  (repeat_delay_q),
		.repeat_period (repeat_period_q),
		.burst         (enc_burst)
	);

	// Output byte register: loads a whole sequence, then shifts one byte per byte taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= '0;
		end else if (advance) begin
			remaining_q <= enc_burst.count;
		end else if (take) begin
			remaining_q <= remaining_q - hid2xt_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			bytes_q <= enc_burst.bytes;
			leds_q  <= enc_burst.leds;
		end else if (take) begin
			bytes_q <= {8'h00, bytes_q[hid2xt_pkg::BURST_MAX-1:1]};
		end
	end

	assign codes.valid     = (remaining_q != '0);
	assign codes.scan_byte = bytes_q[0];
	assign codes.last_byte = (remaining_q == hid2xt_pkg::CNT_W'(1));
	assign codes.lock_leds = leds_q;

	// The byte count never exceeds the longest sequence.
	a_remaining_bound: assert property (@(posedge clk) disable iff (!arst_n)
		remaining_q <= hid2xt_pkg::CNT_W'(hid2xt_pkg::BURST_MAX))
		else $error("byte count out of range");

	// A committed item loads exactly its byte count.
	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> remaining_q == $past(enc_burst.count))
		else $error("byte count not loaded on commit");

	// A byte taken from the middle of a sequence leaves one fewer pending.
	a_shift_count: assert property (@(posedge clk) disable iff (!arst_n)
		take && remaining_q > hid2xt_pkg::CNT_W'(1) |=>
			remaining_q == $past(remaining_q) - hid2xt_pkg::CNT_W'(1))
		else $error("byte count not decremented");

	// No new item is committed while bytes of an earlier one are still held.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		advance && remaining_q > hid2xt_pkg::CNT_W'(1) |-> 1'b0)
		else $error("sequence overwritten before it was sent");

endmodule

// ===== rtl/hid2xt_encode.sv =====
// ----------------------------------------------------------------------------
// hid2xt_encode: key state and scan code sequence builder
// Holds the LED, repeat key and repeat timer state, and works out the bytes
// that one item causes. State is updated when the item is committed.
// ----------------------------------------------------------------------------
module hid2xt_encode (
	input  logic                           clk,
	input  logic                           arst_n,
	input  hid2xt_pkg::item_t              item,
	input  logic                           commit,
	input  logic [hid2xt_pkg::CFG_W-1:0]   repeat_delay,
	input  logic [hid2xt_pkg::CFG_W-1:0]   repeat_period,
	output hid2xt_pkg::burst_t             burst
);

	logic [2:0]                     led_q;
	logic [7:0]                     repeat_usage_q;
	logic [hid2xt_pkg::CFG_W-1:0]   countdown_q;
	logic                           armed_q;

	logic [2:0]                     led_d;
	logic [7:0]                     repeat_usage_d;
	logic [hid2xt_pkg::CFG_W-1:0]   countdown_d;
	logic                           armed_d;
	logic [7:0]                     key_code;
	logic [7:0]                     rep_code;

	assign key_code = hid2xt_pkg::make_code(item.usage_code) |
		(item.pressed ? 8'h00 : hid2xt_pkg::XT_BREAK_BIT);
	assign rep_code = hid2xt_pkg::make_code(repeat_usage_q);

	// Next state and the byte sequence of the item in the input register.
	always_comb begin
		led_d          = led_q;
		repeat_usage_d = repeat_usage_q;
		countdown_d    = countdown_q;
		armed_d        = armed_q;
		burst.bytes    = '0;
		burst.count    = '0;
		case (hid2xt_pkg::action_t'(item.action))
			hid2xt_pkg::ACT_KEY: begin
				if (hid2xt_pkg::is_mapped(item.usage_code)) begin
					// Lock keys toggle their LED on the press.
					if (item.pressed && item.usage_code == hid2xt_pkg::USAGE_NUM_LOCK) begin
						led_d[hid2xt_pkg::LED_NUM] = ~led_q[hid2xt_pkg::LED_NUM];
					end
					if (item.pressed && item.usage_code == hid2xt_pkg::USAGE_CAPS_LOCK) begin
						led_d[hid2xt_pkg::LED_CAPS] = ~led_q[hid2xt_pkg::LED_CAPS];
					end
					if (item.pressed && item.usage_code == hid2xt_pkg::USAGE_SCROLL) begin
						led_d[hid2xt_pkg::LED_SCROLL] = ~led_q[hid2xt_pkg::LED_SCROLL];
					end
					if (item.usage_code == hid2xt_pkg::USAGE_PAUSE) begin
						// Pause never repeats; with Ctrl held it is sent as Break.
						repeat_usage_d = 8'h00;
						if (item.pressed) begin
							if ((item.modifier_bits & hid2xt_pkg::CTRL_MASK) != 8'h00) begin
								burst.bytes[0] = hid2xt_pkg::XT_EXT_PREFIX;
								burst.bytes[1] = hid2xt_pkg::XT_SCROLL_MAKE;
								burst.bytes[2] = hid2xt_pkg::XT_EXT_PREFIX;
								burst.bytes[3] = hid2xt_pkg::XT_SCROLL_BREAK;
								burst.count    = 3'd4;
							end else begin
								burst.bytes[0] = hid2xt_pkg::XT_PAUSE_PREFIX;
								burst.bytes[1] = hid2xt_pkg::XT_CTRL_MAKE;
								burst.bytes[2] = hid2xt_pkg::XT_NUM_MAKE;
								burst.bytes[3] = hid2xt_pkg::XT_PAUSE_PREFIX;
								burst.bytes[4] = hid2xt_pkg::XT_CTRL_BREAK;
								burst.bytes[5] = hid2xt_pkg::XT_NUM_BREAK;
								burst.count    = 3'd6;
							end
						end
					end else begin
						// A press arms the repeat timer; releasing the repeating key ends its repeat.
						if (item.pressed) begin
							repeat_usage_d = item.usage_code;
							armed_d        = 1'b1;
							countdown_d    = repeat_delay;
						end else if (item.usage_code == repeat_usage_q) begin
							repeat_usage_d = 8'h00;
						end
						if (hid2xt_pkg::is_extended(item.usage_code)) begin
							burst.bytes[0] = hid2xt_pkg::XT_EXT_PREFIX;
							burst.bytes[1] = key_code;
							burst.count    = 3'd2;
						end else begin
							burst.bytes[0] = key_code;
							burst.count    = 3'd1;
						end
					end
				end
			end
			hid2xt_pkg::ACT_TICK: begin
				if (armed_q) begin
					if (countdown_q > hid2xt_pkg::CFG_W'(1)) begin
						countdown_d = countdown_q - hid2xt_pkg::CFG_W'(1);
					end else if (repeat_usage_q != 8'h00) begin
						// Timer expired with a key held: send its make code again.
						countdown_d = repeat_period;
						if (hid2xt_pkg::is_extended(repeat_usage_q)) begin
							burst.bytes[0] = hid2xt_pkg::XT_EXT_PREFIX;
							burst.bytes[1] = rep_code;
							burst.count    = 3'd2;
						end else begin
							burst.bytes[0] = rep_code;
							burst.count    = 3'd1;
						end
					end else begin
						armed_d     = 1'b0;
						countdown_d = '0;
					end
				end
			end
			hid2xt_pkg::ACT_HOST_RESET: begin
				burst.bytes[0] = hid2xt_pkg::XT_SELF_TEST_OK;
				burst.count    = 3'd1;
				led_d          = 3'b000;
				repeat_usage_d = 8'h00;
				armed_d        = 1'b0;
				countdown_d    = '0;
			end
			default: begin
			end
		endcase
		burst.leds = led_d;
	end

	// Key state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_q          <= 3'b000;
			repeat_usage_q <= 8'h00;
			countdown_q    <= '0;
			armed_q        <= 1'b0;
		end else if (commit) begin
			led_q          <= led_d;
			repeat_usage_q <= repeat_usage_d;
			countdown_q    <= countdown_d;
			armed_q        <= armed_d;
		end
	end

endmodule

// ===== dv/tb_usb_hid_to_xt_scancode_translator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_usb_hid_to_xt_scancode_translator: self-checking bench for the translator
// Feeds key events, microsecond ticks and host resets through the event
// channel in random bursts. A behavioural translator predicts every XT byte,
// and each byte taken from the code channel is compared with it as it comes.
// ----------------------------------------------------------------------------
module tb_usb_hid_to_xt_scancode_translator;
	import hid2xt_pkg::*;

	// The fourth action code has no meaning and must be ignored.
	localparam logic [1:0] ACT_IGNORED = 2'd3;
	localparam logic [CFG_W-1:0] TICKS_MAX = 20'hfffff;

	// Set-1 make codes of usages 0x00 to 0x73.
	localparam logic [7:0] SET1_MAKE [0:115] = '{
		8'h00, 8'hff, 8'hfc, 8'h00, 8'h1e, 8'h30, 8'h2e, 8'h20,
		8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24, 8'h25, 8'h26,
		8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1f, 8'h14,
		8'h16, 8'h2f, 8'h11, 8'h2d, 8'h15, 8'h2c, 8'h02, 8'h03,
		8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a, 8'h0b,
		8'h1c, 8'h01, 8'h0e, 8'h0f, 8'h39, 8'h0c, 8'h0d, 8'h1a,
		8'h1b, 8'h2b, 8'h2b, 8'h27, 8'h28, 8'h29, 8'h33, 8'h34,
		8'h35, 8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e, 8'h3f, 8'h40,
		8'h41, 8'h42, 8'h43, 8'h44, 8'h57, 8'h58, 8'h37, 8'h46,
		8'h46, 8'h52, 8'h47, 8'h49, 8'h53, 8'h4f, 8'h51, 8'h4d,
		8'h4b, 8'h50, 8'h48, 8'h45, 8'h35, 8'h37, 8'h4a, 8'h4e,
		8'h1c, 8'h4f, 8'h50, 8'h51, 8'h4b, 8'h4c, 8'h4d, 8'h47,
		8'h48, 8'h49, 8'h52, 8'h53, 8'h56, 8'h5d, 8'h5e, 8'h59,
		8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6a, 8'h6b,
		8'h6c, 8'h6d, 8'h6e, 8'h76
	};

	// Set-1 make codes of the modifier usages 0xE0 to 0xE7.
	localparam logic [7:0] SET1_MOD [0:7] = '{
		8'h1d, 8'h2a, 8'h38, 8'h5b, 8'h1d, 8'h36, 8'h38, 8'h5c
	};

	// One byte as expected on the code channel.
	typedef struct packed {
		logic [7:0] scan_byte;
		logic       last_byte;
		logic [2:0] lock_leds;
	} xt_code_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	hid2xt_in_if  ev_if ();
	hid2xt_out_if xt_if ();

	usb_hid_to_xt_scancode_translator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.events    (ev_if),
		.codes     (xt_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Items waiting to be sent, and the bytes still owed by the block.
	item_t    key_items [$];
	xt_code_t scan_codes_due [$];
	int       n_queued = 0;
	int       n_taken = 0;
	int       n_errors = 0;

	// Translator state as the bench sees it.
	logic [2:0]       led_state = '0;
	logic [7:0]       typematic_usage = '0;
	logic [CFG_W-1:0] typematic_count = '0;
	logic             typematic_on = 1'b0;
	logic [CFG_W-1:0] delay_ticks = REPEAT_DELAY_RST;
	logic [CFG_W-1:0] period_ticks = REPEAT_PERIOD_RST;

	// Sender burst and receiver stall state.
	int       burst_left = 4;
	int       idle_gap = 0;
	logic [5:0] stall_phase = '0;
	int       stall_mode = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic key_known(input logic [7:0] u);
		return (u <= USAGE_LAST_PLAIN) || (u >= USAGE_FIRST_MOD && u <= USAGE_LAST_MOD);
	endfunction

	function automatic logic takes_e0(input logic [7:0] u);
		return u inside {8'h46, [8'h49:8'h52], 8'h54, 8'h58, 8'h65, 8'h66,
			8'he3, 8'he4, [8'he6:8'hff]};
	endfunction

	function automatic logic [7:0] set1_code(input logic [7:0] u);
		if (u >= USAGE_FIRST_MOD) begin
			return SET1_MOD[u[2:0]];
		end
		return SET1_MAKE[u[6:0]];
	endfunction

	// Work out the bytes one accepted item causes and update the state.
	task automatic translate_item(input item_t it);
		logic [7:0] seq [0:5];
		logic [7:0] u;
		int         n;
		int         k;
		xt_code_t   c;
		n = 0;
		u = it.usage_code;
		case (it.action)
			ACT_KEY: begin
				if (key_known(u)) begin
					if (it.pressed && u == USAGE_NUM_LOCK) led_state[LED_NUM] = ~led_state[LED_NUM];
					if (it.pressed && u == USAGE_CAPS_LOCK) led_state[LED_CAPS] = ~led_state[LED_CAPS];
					if (it.pressed && u == USAGE_SCROLL) led_state[LED_SCROLL] = ~led_state[LED_SCROLL];
					if (u == USAGE_PAUSE) begin
						// Pause stops any repeat but leaves the timer running.
						typematic_usage = '0;
						if (it.pressed && (it.modifier_bits & CTRL_MASK) != 0) begin
							seq[0] = XT_EXT_PREFIX;
							seq[1] = XT_SCROLL_MAKE;
							seq[2] = XT_EXT_PREFIX;
							seq[3] = XT_SCROLL_BREAK;
							n = 4;
						end else if (it.pressed) begin
							seq[0] = XT_PAUSE_PREFIX;
							seq[1] = XT_CTRL_MAKE;
							seq[2] = XT_NUM_MAKE;
							seq[3] = XT_PAUSE_PREFIX;
							seq[4] = XT_CTRL_BREAK;
							seq[5] = XT_NUM_BREAK;
							n = 6;
						end
					end else begin
						if (it.pressed) begin
							typematic_usage = u;
							typematic_on = 1'b1;
							typematic_count = delay_ticks;
						end else if (u == typematic_usage) begin
							typematic_usage = '0;
						end
						if (takes_e0(u)) begin
							seq[n] = XT_EXT_PREFIX;
							n++;
						end
						seq[n] = it.pressed ? set1_code(u) : (set1_code(u) | XT_BREAK_BIT);
						n++;
					end
				end
			end
			ACT_TICK: begin
				if (typematic_on) begin
					if (typematic_count > 1) begin
						typematic_count--;
					end else if (typematic_usage != 0) begin
						if (takes_e0(typematic_usage)) begin
							seq[n] = XT_EXT_PREFIX;
							n++;
						end
						seq[n] = set1_code(typematic_usage);
						n++;
						typematic_count = period_ticks;
					end else begin
						typematic_on = 1'b0;
						typematic_count = '0;
					end
				end
			end
			ACT_HOST_RESET: begin
				seq[0] = XT_SELF_TEST_OK;
				n = 1;
				led_state = '0;
				typematic_usage = '0;
				typematic_on = 1'b0;
				typematic_count = '0;
			end
			default: ;
		endcase
		for (k = 0; k < n; k++) begin
			c.scan_byte = seq[k];
			c.last_byte = (k == n - 1);
			c.lock_leds = led_state;
			scan_codes_due.push_back(c);
		end
	endtask

	// Event sender: bursts of random length separated by random gaps.
	always @(posedge clk) begin : drive_events
		item_t nxt;
		if (!arst_n) begin
			ev_if.valid <= 1'b0;
		end else if (!ev_if.valid || ev_if.ready) begin
			if (idle_gap > 0) begin
				idle_gap <= idle_gap - 1;
				ev_if.valid <= 1'b0;
			end else if (key_items.size() > 0) begin
				nxt = key_items.pop_front();
				ev_if.valid <= 1'b1;
				ev_if.action <= nxt.action;
				ev_if.usage_code <= nxt.usage_code;
				ev_if.pressed <= nxt.pressed;
				ev_if.modifier_bits <= nxt.modifier_bits;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 12);
					idle_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				ev_if.valid <= 1'b0;
			end
		end
	end

	// Predict as each item is accepted.
	always @(posedge clk) begin : take_events
		item_t it;
		if (arst_n && ev_if.valid && ev_if.ready) begin
			it.action = ev_if.action;
			it.usage_code = ev_if.usage_code;
			it.pressed = ev_if.pressed;
			it.modifier_bits = ev_if.modifier_bits;
			translate_item(it);
			n_taken <= n_taken + 1;
		end
	end

	// Code receiver: a new stall style is drawn whenever the six-bit phase wraps.
	always @(posedge clk) begin
		if (!arst_n) begin
			xt_if.ready <= 1'b0;
		end else begin
			stall_phase <= stall_phase + 1'b1;
			if (stall_phase == 6'd63) stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: xt_if.ready <= 1'b1;
				1: xt_if.ready <= 1'($urandom_range(0, 1));
				2: xt_if.ready <= ($urandom_range(0, 3) == 0);
				default: xt_if.ready <= (stall_phase[1:0] != 2'd3);
			endcase
		end
	end

	// Compare each byte taken with the oldest one owed.
	always @(posedge clk) begin : check_codes
		xt_code_t want;
		if (arst_n && xt_if.valid && xt_if.ready) begin
			if (scan_codes_due.size() == 0) begin
				$display("%0t: unexpected scan byte %02h (last_byte %0b, lock_leds %03b)",
					$time, xt_if.scan_byte, xt_if.last_byte, xt_if.lock_leds);
				n_errors++;
			end else begin
				want = scan_codes_due.pop_front();
				if (xt_if.scan_byte !== want.scan_byte) begin
					$display("%0t: scan_byte expected %02h, got %02h",
						$time, want.scan_byte, xt_if.scan_byte);
					n_errors++;
				end
				if (xt_if.last_byte !== want.last_byte) begin
					$display("%0t: last_byte expected %0b, got %0b",
						$time, want.last_byte, xt_if.last_byte);
					n_errors++;
				end
				if (xt_if.lock_leds !== want.lock_leds) begin
					$display("%0t: lock_leds expected %03b, got %03b",
						$time, want.lock_leds, xt_if.lock_leds);
					n_errors++;
				end
			end
		end
	end

	task automatic add_event(input logic [1:0] act, input logic [7:0] u, input logic p,
		input logic [7:0] m);
		item_t it;
		it.action = act;
		it.usage_code = u;
		it.pressed = p;
		it.modifier_bits = m;
		key_items.push_back(it);
		n_queued++;
	endtask

	task automatic add_ticks(input int count);
		repeat (count) add_event(ACT_TICK, 8'($urandom_range(0, 255)),
			1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
	endtask

	function automatic logic [7:0] pick_usage();
		if ($urandom_range(0, 4) == 0) return 8'($urandom_range(USAGE_FIRST_MOD, USAGE_LAST_MOD));
		return 8'($urandom_range(0, USAGE_LAST_PLAIN));
	endfunction

	// Wait until every item is taken and every byte has arrived, then let
	// items that cause no byte drain out of the pipeline.
	task automatic settle();
		while (n_taken != n_queued || scan_codes_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_REPEAT_DELAY) delay_ticks = val;
		else period_ticks = val;
	endtask

	// Mostly press, ticks, release sequences, with lock keys, Pause, host
	// resets and random noise mixed in.
	task automatic add_random_traffic(input int target);
		int         start;
		int         kind;
		logic [7:0] u;
		logic [7:0] m;
		start = n_queued;
		while (n_queued - start < target) begin
			kind = $urandom_range(0, 9);
			m = 8'($urandom_range(0, 255));
			if (kind <= 4) begin
				u = pick_usage();
				add_event(ACT_KEY, u, 1'b1, m);
				add_ticks($urandom_range(0, 10));
				if ($urandom_range(0, 3) != 0) add_event(ACT_KEY, u, 1'b0, m);
			end else if (kind == 5) begin
				case ($urandom_range(0, 2))
					0: u = USAGE_NUM_LOCK;
					1: u = USAGE_CAPS_LOCK;
					default: u = USAGE_SCROLL;
				endcase
				add_event(ACT_KEY, u, 1'b1, m);
				add_event(ACT_KEY, u, 1'b0, m);
			end else if (kind == 6) begin
				if ($urandom_range(0, 1) == 0) m = m & ~CTRL_MASK;
				add_event(ACT_KEY, USAGE_PAUSE, 1'b1, m);
				add_ticks($urandom_range(0, 3));
				if ($urandom_range(0, 1) == 0) add_event(ACT_KEY, USAGE_PAUSE, 1'b0, m);
			end else if (kind == 7) begin
				add_ticks($urandom_range(1, 4));
			end else if (kind == 8) begin
				add_event(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), m);
			end else if ($urandom_range(0, 2) == 0) begin
				add_event(ACT_HOST_RESET, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), m);
			end else begin
				u = 8'($urandom_range(8'h74, 8'hff));
				if (u >= USAGE_FIRST_MOD && u <= USAGE_LAST_MOD) u = 8'hdf;
				add_event(ACT_KEY, u, 1'($urandom_range(0, 1)), m);
			end
		end
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		ev_if.valid = 1'b0;
		ev_if.action = ACT_KEY;
		ev_if.usage_code = '0;
		ev_if.pressed = 1'b0;
		ev_if.modifier_bits = '0;
		xt_if.ready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: plain, modifier, extended, lock and Pause keys.
		add_event(ACT_HOST_RESET, 8'h00, 1'b0, 8'h00);
		add_event(ACT_KEY, 8'h04, 1'b1, 8'h00);
		add_event(ACT_KEY, 8'h04, 1'b0, 8'h00);
		add_event(ACT_KEY, 8'h00, 1'b1, 8'h00);
		add_event(ACT_KEY, USAGE_LAST_PLAIN, 1'b1, 8'hff);
		add_event(ACT_KEY, USAGE_FIRST_MOD, 1'b1, 8'h01);
		add_event(ACT_KEY, USAGE_LAST_MOD, 1'b1, 8'h80);
		add_event(ACT_KEY, USAGE_LAST_MOD, 1'b0, 8'h00);
		add_event(ACT_KEY, 8'h74, 1'b1, 8'h00);
		add_event(ACT_KEY, 8'hdf, 1'b1, 8'h00);
		add_event(ACT_KEY, 8'he8, 1'b1, 8'h00);
		add_event(ACT_KEY, 8'hff, 1'b0, 8'hff);
		add_event(ACT_KEY, USAGE_NUM_LOCK, 1'b1, 8'h00);
		add_event(ACT_KEY, USAGE_NUM_LOCK, 1'b0, 8'h00);
		add_event(ACT_KEY, USAGE_CAPS_LOCK, 1'b1, 8'h00);
		add_event(ACT_KEY, USAGE_SCROLL, 1'b1, 8'h00);
		add_event(ACT_KEY, USAGE_PAUSE, 1'b1, 8'hee);
		add_event(ACT_KEY, USAGE_PAUSE, 1'b1, 8'h01);
		add_event(ACT_KEY, USAGE_PAUSE, 1'b1, 8'h10);
		add_event(ACT_KEY, USAGE_PAUSE, 1'b0, 8'h11);
		add_event(ACT_KEY, 8'h46, 1'b1, 8'h00);
		add_event(ACT_KEY, 8'h58, 1'b0, 8'h00);
		add_ticks(2);
		add_event(ACT_IGNORED, 8'hff, 1'b1, 8'hff);
		add_event(ACT_HOST_RESET, 8'hff, 1'b1, 8'hff);
		settle();

		// Shortest timings: repeat of an extended key, stop on release, a
		// repeat cut short by Pause, and usage zero that never repeats.
		write_reg(CFG_REPEAT_DELAY, 20'd1);
		write_reg(CFG_REPEAT_PERIOD, 20'd1);
		add_event(ACT_KEY, 8'h52, 1'b1, 8'h00);
		add_ticks(2);
		add_event(ACT_KEY, 8'h52, 1'b0, 8'h00);
		add_ticks(2);
		add_event(ACT_KEY, 8'h04, 1'b1, 8'h00);
		add_ticks(1);
		add_event(ACT_KEY, USAGE_PAUSE, 1'b1, 8'h00);
		add_ticks(2);
		add_event(ACT_KEY, 8'h00, 1'b1, 8'h00);
		add_ticks(2);
		add_random_traffic(12);
		settle();

		write_reg(CFG_REPEAT_DELAY, 20'd3);
		write_reg(CFG_REPEAT_PERIOD, 20'd2);
		add_random_traffic(15);
		settle();

		write_reg(CFG_REPEAT_DELAY, 20'($urandom_range(1, 8)));
		write_reg(CFG_REPEAT_PERIOD, 20'($urandom_range(1, 8)));
		add_random_traffic(15);
		settle();

		// Longest timings: the timer only counts.
		write_reg(CFG_REPEAT_DELAY, TICKS_MAX);
		write_reg(CFG_REPEAT_PERIOD, TICKS_MAX);
		add_random_traffic(10);
		settle();

		write_reg(CFG_REPEAT_DELAY, 20'd1);
		write_reg(CFG_REPEAT_PERIOD, 20'd5);
		add_random_traffic(15);
		settle();
		repeat (20) @(posedge clk);

		if (n_errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/hid2xt_pkg.sv
rtl/hid2xt_in_if.sv
rtl/hid2xt_out_if.sv
rtl/hid2xt_encode.sv
rtl/usb_hid_to_xt_scancode_translator.sv
dv/tb_usb_hid_to_xt_scancode_translator.sv
